// ===== src/smdfm_pkg.sv =====
// ----------------------------------------------------------------------------
// smdfm_pkg
// shared widths, register indexes, channel modes and divider handshake types
// ----------------------------------------------------------------------------
`default_nettype none

package smdfm_pkg;

	// field widths
	localparam int unsigned SMP_W      = 16;  // input sample
	localparam int unsigned FRAC_BITS  = 8;   // output fraction bits
	localparam int unsigned Y_W        = 25;  // output sample, block mean, dc estimate
	localparam int unsigned ACC_W      = 29;  // block accumulator
	localparam int unsigned BS_W       = 12;  // block size
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 12;

	// divider dividend: accumulator magnitude scaled by the fraction bits
	localparam int unsigned DIV_W      = ACC_W - 1 + FRAC_BITS;

	// defaults
	localparam int unsigned DC_TAPS_DEF    = 17 * 2;
	localparam logic [BS_W-1:0] BLOCK_SIZE_RST = BS_W'(1280);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_SIZE    = 2'd0,
		REG_CHANNEL_MODE  = 2'd1,
		REG_FLIP_SPECTRUM = 2'd2
	} reg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_MIX   = 2'd0,
		MODE_LEFT  = 2'd1,
		MODE_RIGHT = 2'd2
	} chan_mode_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] numer;
		logic [BS_W-1:0]  denom;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== src/smdfm_in_if.sv =====
// ----------------------------------------------------------------------------
// smdfm_in_if
// stereo sample channel, one left/right pair per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface smdfm_in_if
	import smdfm_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] left_sample;
	logic signed [SMP_W-1:0] right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

// ===== src/smdfm_out_if.sv =====
// ----------------------------------------------------------------------------
// smdfm_out_if
// conditioned sample channel with block end flag and block peak
// ----------------------------------------------------------------------------
`default_nettype none

interface smdfm_out_if
	import smdfm_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic signed [Y_W-1:0] sample_out;
	logic                  block_last;
	logic [Y_W-1:0]        block_peak;

	modport source (output valid, output sample_out, output block_last, output block_peak,
		input ready);
	modport sink (input valid, input sample_out, input block_last, input block_peak,
		output ready);
endinterface

`default_nettype wire

// ===== src/smdfm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// smdfm_cfg_if
// register write channel, index and data per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface smdfm_cfg_if
	import smdfm_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/smdfm_ram.sv =====
// ----------------------------------------------------------------------------
// smdfm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module smdfm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/smdfm_div.sv =====
// ----------------------------------------------------------------------------
// smdfm_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module smdfm_div
	import smdfm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned STEP_W = $clog2(DIV_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  num_q;   // dividend bits out at the top, quotient bits in at the bottom
	logic [BS_W-1:0]   rem_q;
	logic [BS_W-1:0]   den_q;

	logic [BS_W:0] trial;
	logic          fits;
	logic [BS_W:0] diff;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIV_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.numer;
			rem_q <= '0;
			den_q <= req.denom;
		end else if (busy_q) begin
			rem_q <= fits ? diff[BS_W-1:0] : trial[BS_W-1:0];
			num_q <= {num_q[DIV_W-2:0], fits};
		end
	end

	// a start in flight counts as busy
	assign rsp.busy = busy_q | req.start;
	assign rsp.quot = num_q;

endmodule

`default_nettype wire

// ===== src/stereo_mix_dc_block_flip_meter_unit.sv =====
// ----------------------------------------------------------------------------
// stereo_mix_dc_block_flip_meter_unit
// item flow: accept, bit-serial pass set by the accumulator width, finish,
//   result load into the output register, which waits while results stall
// a block end adds two 36-step serial divisions (block mean, dc estimate)
//   and the ring update; no new input is taken until the item is done
// reset: arst_n clears control, config and sum registers and ring valid bits at once
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_mix_dc_block_flip_meter_unit
	import smdfm_pkg::*;
#(
	parameter int unsigned DC_TAPS = DC_TAPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	smdfm_in_if.sink    samples,
	smdfm_out_if.source results,
	smdfm_cfg_if.sink   cfg
);

	localparam int unsigned PTR_W = $clog2(DC_TAPS);
	// ring total: sum of DC_TAPS block means
	localparam int unsigned TOT_W = Y_W + PTR_W;
	localparam int unsigned CNT_W = $clog2(ACC_W);
	// sign extension bit above the shifted sample
	localparam int unsigned EXT_W = Y_W - SMP_W - FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHIFT,      // bit-serial pass, lsb first
		ST_FINISH,     // peak select, position update, mean division kick-off
		ST_PUSH,       // wait for the output register
		ST_MEAN_WAIT,
		ST_RING_SUB,   // drop the oldest mean, write the new one
		ST_RING_ADD,
		ST_DC_GO,
		ST_DC_WAIT
	} state_t;

	// ------------------------------------------------------------------------
	// configuration registers, writes taken every cycle
	// ------------------------------------------------------------------------
	logic [BS_W-1:0]   block_size_q;
	logic [MODE_W-1:0] channel_mode_q;
	logic              flip_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= BLOCK_SIZE_RST;
			channel_mode_q <= MODE_MIX;
			flip_q         <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BLOCK_SIZE:    block_size_q   <= cfg.data[BS_W-1:0];
				REG_CHANNEL_MODE:  channel_mode_q <= cfg.data[MODE_W-1:0];
				REG_FLIP_SPECTRUM: flip_q         <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// state
	// ------------------------------------------------------------------------
	state_t state_q;

	logic [CNT_W-1:0]          cnt_q;
	logic [BS_W-1:0]           pos_q;
	logic                      phase_q;     // 0: next flipped sample is negated
	logic                      neg_q;       // negate this item
	logic                      last_q;
	logic                      even_q;

	// serial operands and results, all shifting right
	logic [Y_W-1:0]            a_sr_q;      // scaled source
	logic [Y_W-1:0]            b_sr_q;      // dc estimate or zero
	logic [ACC_W-1:0]          add_sr_q;    // mix average or zero
	logic [Y_W-1:0]            y_sr_q;      // output sample
	logic [Y_W-1:0]            z_sr_q;      // its negation
	logic                      cy_d_q;
	logic                      cy_n_q;
	logic                      cy_a_q;
	logic                      gt_y_q;      // |y| > peak when y >= 0
	logic                      gt_z_q;      // |y| > peak when y < 0

	logic signed [ACC_W-1:0]   acc_q;       // rotates during the pass
	logic [Y_W-1:0]            peak_q;      // rotates during the pass
	logic [Y_W-1:0]            res_peak_q;

	logic                      quo_neg_q;
	logic signed [Y_W-1:0]     mean_q;
	logic signed [TOT_W-1:0]   total_q;
	logic signed [Y_W-1:0]     dc_q;
	logic [PTR_W-1:0]          ptr_q;
	logic [DC_TAPS-1:0]        ring_vld_q;  // entry written since reset
	div_req_t                  div_req_q;
	div_rsp_t                  div_rsp;

	logic                      out_valid_q;
	logic signed [Y_W-1:0]     out_sample_q;
	logic                      out_last_q;
	logic [Y_W-1:0]            out_peak_q;

	// ------------------------------------------------------------------------
	// accept side: mix average truncated toward zero, block position tests
	// ------------------------------------------------------------------------
	logic [SMP_W:0]   pair_sum;
	logic [SMP_W:0]   pair_adj;
	logic [SMP_W-1:0] avg;
	logic [SMP_W-1:0] raw_smp;
	logic             mix;
	logic [BS_W-1:0]  bs_eff;
	logic             last_now;

	assign pair_sum = {samples.left_sample[SMP_W-1], samples.left_sample}
		+ {samples.right_sample[SMP_W-1], samples.right_sample};
	// negative sums are bumped by one so the arithmetic shift rounds toward zero
	assign pair_adj = pair_sum + {{SMP_W{1'b0}}, pair_sum[SMP_W]};
	assign avg      = pair_adj[SMP_W:1];
	assign mix      = channel_mode_q == MODE_MIX;
	// unused mode code falls through to the right channel
	assign raw_smp  = (channel_mode_q == MODE_LEFT) ? samples.left_sample : samples.right_sample;
	// zero block size acts as one
	assign bs_eff   = (block_size_q == '0) ? BS_W'(1) : block_size_q;
	assign last_now = ({1'b0, pos_q} + (BS_W + 1)'(1)) >= {1'b0, bs_eff};

	assign samples.ready = state_q == ST_IDLE;

	// ------------------------------------------------------------------------
	// one bit of each serial chain per cycle
	// ------------------------------------------------------------------------
	logic a_bit, b_bit, p_bit;
	logic d_bit, d_cy, n_bit, n_cy;
	logic y_bit, z_bit;
	logic s_bit, s_cy;
	logic y_phase;

	assign a_bit = a_sr_q[0];
	assign b_bit = b_sr_q[0];
	assign p_bit = peak_q[0];

	// a - b and b - a as add-with-inverse, carry in preset to one
	assign d_bit = a_bit ^ ~b_bit ^ cy_d_q;
	assign d_cy  = (a_bit & ~b_bit) | (a_bit & cy_d_q) | (~b_bit & cy_d_q);
	assign n_bit = b_bit ^ ~a_bit ^ cy_n_q;
	assign n_cy  = (b_bit & ~a_bit) | (b_bit & cy_n_q) | (~a_bit & cy_n_q);

	// flip picks which chain is the output and which its negation
	assign y_bit = neg_q ? n_bit : d_bit;
	assign z_bit = neg_q ? d_bit : n_bit;

	// accumulator add
	assign s_bit = acc_q[0] ^ add_sr_q[0] ^ cy_a_q;
	assign s_cy  = (acc_q[0] & add_sr_q[0]) | (acc_q[0] & cy_a_q) | (add_sr_q[0] & cy_a_q);

	// sample chains stop after the output width, the accumulator runs on
	assign y_phase = cnt_q < CNT_W'(Y_W);

	// ------------------------------------------------------------------------
	// finish: magnitude and peak, divider operands
	// ------------------------------------------------------------------------
	logic             y_neg;
	logic [Y_W-1:0]   mag;
	logic             mag_gt;
	logic [Y_W-1:0]   peak_new;
	logic [ACC_W-1:0] acc_mag;
	logic [TOT_W-1:0] tot_mag;
	logic [Y_W-1:0]   quot_lo;
	logic [Y_W-1:0]   quot_signed;

	assign y_neg    = y_sr_q[Y_W-1];
	assign mag      = y_neg ? z_sr_q : y_sr_q;
	assign mag_gt   = y_neg ? gt_z_q : gt_y_q;
	// only even positions feed the meter
	assign peak_new = (even_q && mag_gt) ? mag : peak_q;
	assign acc_mag  = acc_q[ACC_W-1] ? -acc_q : acc_q;
	assign tot_mag  = total_q[TOT_W-1] ? -total_q : total_q;
	assign quot_lo  = div_rsp.quot[Y_W-1:0];
	assign quot_signed = quo_neg_q ? -quot_lo : quot_lo;

	// ------------------------------------------------------------------------
	// ring of block means
	// ------------------------------------------------------------------------
	logic                  ring_we;
	logic [Y_W-1:0]        ring_rd;
	logic signed [Y_W-1:0] ring_old;

	assign ring_we  = state_q == ST_RING_SUB;
	// an entry never written since reset reads as zero
	assign ring_old = ring_vld_q[ptr_q] ? ring_rd : '0;

	smdfm_ram #(
		.WIDTH (Y_W),
		.DEPTH (DC_TAPS)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ptr_q),
		.wdata (mean_q),
		.raddr (ptr_q),
		.rdata (ring_rd)
	);

	smdfm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------------
	// control and datapath registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			phase_q     <= 1'b0;
			neg_q       <= 1'b0;
			last_q      <= 1'b0;
			even_q      <= 1'b0;
			acc_q       <= '0;
			peak_q      <= '0;
			total_q     <= '0;
			dc_q        <= '0;
			ptr_q       <= '0;
			ring_vld_q  <= '0;
			div_req_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						a_sr_q   <= mix
							? {{EXT_W{avg[SMP_W-1]}}, avg, {FRAC_BITS{1'b0}}}
							: {{EXT_W{raw_smp[SMP_W-1]}}, raw_smp, {FRAC_BITS{1'b0}}};
						b_sr_q   <= mix ? dc_q : '0;
						add_sr_q <= mix ? {{(ACC_W - SMP_W){avg[SMP_W-1]}}, avg} : '0;
						cy_d_q   <= 1'b1;
						cy_n_q   <= 1'b1;
						cy_a_q   <= 1'b0;
						gt_y_q   <= 1'b0;
						gt_z_q   <= 1'b0;
						neg_q    <= flip_q & ~phase_q;
						if (flip_q) begin
							phase_q <= ~phase_q;
						end
						last_q   <= last_now;
						even_q   <= ~pos_q[0];
						cnt_q    <= '0;
						state_q  <= ST_SHIFT;
					end
				end

				ST_SHIFT: begin
					acc_q    <= {s_bit, acc_q[ACC_W-1:1]};
					add_sr_q <= {1'b0, add_sr_q[ACC_W-1:1]};
					cy_a_q   <= s_cy;
					if (y_phase) begin
						a_sr_q <= {1'b0, a_sr_q[Y_W-1:1]};
						b_sr_q <= {1'b0, b_sr_q[Y_W-1:1]};
						y_sr_q <= {y_bit, y_sr_q[Y_W-1:1]};
						z_sr_q <= {z_bit, z_sr_q[Y_W-1:1]};
						peak_q <= {p_bit, peak_q[Y_W-1:1]};
						cy_d_q <= d_cy;
						cy_n_q <= n_cy;
						// lsb-first compare: a later differing bit decides
						gt_y_q <= (y_bit & ~p_bit) | (gt_y_q & ~(y_bit ^ p_bit));
						gt_z_q <= (z_bit & ~p_bit) | (gt_z_q & ~(z_bit ^ p_bit));
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(ACC_W - 1)) begin
						state_q <= ST_FINISH;
					end
				end

				ST_FINISH: begin
					res_peak_q <= last_q ? peak_new : '0;
					if (last_q) begin
						// mean = acc * 2^FRAC / block size, toward zero
						div_req_q.start <= 1'b1;
						div_req_q.numer <= {acc_mag[ACC_W-2:0], {FRAC_BITS{1'b0}}};
						div_req_q.denom <= bs_eff;
						quo_neg_q       <= acc_q[ACC_W-1];
						acc_q           <= '0;
						peak_q          <= '0;
						pos_q           <= '0;
					end else begin
						peak_q <= peak_new;
						pos_q  <= pos_q + BS_W'(1);
					end
					state_q <= ST_PUSH;
				end

				ST_PUSH: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= y_sr_q;
						out_last_q   <= last_q;
						out_peak_q   <= res_peak_q;
						state_q      <= last_q ? ST_MEAN_WAIT : ST_IDLE;
					end
				end

				ST_MEAN_WAIT: begin
					if (!div_rsp.busy) begin
						mean_q  <= quot_signed;
						state_q <= ST_RING_SUB;
					end
				end

				ST_RING_SUB: begin
					// read data is the oldest mean; the new one is written now
					total_q              <= total_q - {{PTR_W{ring_old[Y_W-1]}}, ring_old};
					ring_vld_q[ptr_q]    <= 1'b1;
					state_q              <= ST_RING_ADD;
				end

				ST_RING_ADD: begin
					total_q <= total_q + {{PTR_W{mean_q[Y_W-1]}}, mean_q};
					ptr_q   <= (ptr_q == PTR_W'(DC_TAPS - 1)) ? '0 : ptr_q + PTR_W'(1);
					state_q <= ST_DC_GO;
				end

				ST_DC_GO: begin
					// dc = ring total / taps, toward zero
					div_req_q.start <= 1'b1;
					div_req_q.numer <= DIV_W'(tot_mag);
					div_req_q.denom <= BS_W'(DC_TAPS);
					quo_neg_q       <= total_q[TOT_W-1];
					state_q         <= ST_DC_WAIT;
				end

				ST_DC_WAIT: begin
					if (!div_rsp.busy) begin
						dc_q    <= quot_signed;
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid      = out_valid_q;
	assign results.sample_out = out_sample_q;
	assign results.block_last = out_last_q;
	assign results.block_peak = out_peak_q;

endmodule

`default_nettype wire

// ===== src/smdfm_chk.sv =====
// ----------------------------------------------------------------------------
// smdfm_chk
// port-level checks for the stereo conditioner, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module smdfm_chk
	import smdfm_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input logic [Y_W-1:0] out_sample,
	input logic           out_last,
	input logic [Y_W-1:0] out_peak
);

	// one item at a time: no second input beat right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input beat taken while an item is in work");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last)
			&& $stable(out_peak))
		else $error("result beat changed while stalled");

	// peak shows only at block end
	a_peak_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_peak == '0)
		else $error("peak nonzero outside block end");

	// peak never exceeds full scale magnitude
	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_peak[Y_W-1] |-> out_peak[Y_W-2:0] == '0)
		else $error("peak out of range");

endmodule

bind stereo_mix_dc_block_flip_meter_unit smdfm_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_sample (results.sample_out),
	.out_last   (results.block_last),
	.out_peak   (results.block_peak)
);

`default_nettype wire
